// ----- rtl/core/sms_pkg.sv -----
// ----------------------------------------------------------------------------
// sms_pkg
// Types, character codes and small byte helpers shared by the string
// modifier stream modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sms_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_CASE_MODE  = 3'd0;
  localparam logic [2:0] REG_FIRST_MODE = 3'd1;
  localparam logic [2:0] REG_QUOTE_MODE = 3'd2;
  localparam logic [2:0] REG_URL_ENCODE = 3'd3;
  localparam logic [2:0] REG_LENGTH_ON  = 3'd4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 2;

  // mode codes
  localparam logic [1:0] CASE_LOWER  = 2'd1;
  localparam logic [1:0] CASE_UPPER  = 2'd2;
  localparam logic [1:0] FIRST_LOWER = 2'd1;
  localparam logic [1:0] FIRST_UPPER = 2'd2;
  localparam logic [1:0] FIRST_BOTH  = 2'd3;
  localparam logic [1:0] QUOTE_NONE  = 2'd0;
  localparam logic [1:0] QUOTE_WILD  = 2'd1;

  // character codes
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_UNDERLINE = 8'h5F;
  localparam logic [7:0] CH_DASH      = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_QUESTION  = 8'h3F;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_DOLLAR    = 8'h24;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_BAR       = 8'h7C;

  localparam int SEQ_MAX = 6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    logic       is_empty;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // one queued job: a run of bytes, or a request to print the count
  typedef struct packed {
    logic                      is_count;
    logic                      last;
    logic [2:0]                n;
    logic [SEQ_MAX-1:0][7:0]   seq;
  } entry_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

  function automatic logic is_unreserved(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_DASH || c == CH_DOT ||
           c == CH_UNDERLINE || c == CH_TILDE;
  endfunction

  function automatic logic [7:0] hex_upper(input logic [3:0] v);
    return (v < 4'd10) ? {4'h3, v} : 8'h37 + {4'h0, v};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sms_front.sv -----
// ----------------------------------------------------------------------------
// sms_front
// Holds the configuration and the running byte count, applies case,
// quoting and percent-encoding to each accepted byte and queues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_front #(
  parameter int COUNT_DIGITS = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [sms_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [sms_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire sms_pkg::in_item_t                   in_data,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output sms_pkg::entry_t                          q_entry,
  output logic [COUNT_DIGITS-1:0][3:0]             q_digits
);

  logic [1:0] case_mode;
  logic [1:0] first_mode;
  logic [1:0] quote_mode;
  logic       url_encode_on;
  logic       length_on;
  logic       at_first_byte;
  logic [COUNT_DIGITS-1:0][3:0] count_digits;
  logic [COUNT_DIGITS-1:0][3:0] count_next;

  logic       accept;
  logic [7:0] c_case;
  logic [7:0] c_mod;
  logic       quote;
  logic [2:0] bs_len;
  logic [2:0] ch_len;
  logic [2:0][7:0] bs_bytes;
  logic [2:0][7:0] ch_bytes;
  logic [sms_pkg::SEQ_MAX-1:0][7:0] seq;
  logic [2:0] n;
  logic [4:0] sum0;
  logic       carry;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // case modifiers
  always_comb begin
    if (case_mode == sms_pkg::CASE_LOWER) begin
      c_case = sms_pkg::to_lower(in_data.data_byte);
    end else if (case_mode == sms_pkg::CASE_UPPER) begin
      c_case = sms_pkg::to_upper(in_data.data_byte);
    end else begin
      c_case = in_data.data_byte;
    end
    c_mod = c_case;
    if (at_first_byte) begin
      if (first_mode == sms_pkg::FIRST_LOWER || first_mode == sms_pkg::FIRST_BOTH) begin
        c_mod = sms_pkg::to_lower(c_case);
      end else if (first_mode == sms_pkg::FIRST_UPPER) begin
        c_mod = sms_pkg::to_upper(c_case);
      end
    end
  end

  // quoting
  always_comb begin
    quote = 1'b0;
    if (quote_mode != sms_pkg::QUOTE_NONE) begin
      quote = c_mod == sms_pkg::CH_STAR || c_mod == sms_pkg::CH_QUESTION ||
              c_mod == sms_pkg::CH_BACKSLASH;
      if (quote_mode != sms_pkg::QUOTE_WILD) begin
        quote = quote || c_mod == sms_pkg::CH_DOT || c_mod == sms_pkg::CH_CARET ||
                c_mod == sms_pkg::CH_DOLLAR || c_mod == sms_pkg::CH_PLUS ||
                c_mod == sms_pkg::CH_LPAREN || c_mod == sms_pkg::CH_RPAREN ||
                c_mod == sms_pkg::CH_LBRACKET || c_mod == sms_pkg::CH_LBRACE ||
                c_mod == sms_pkg::CH_BAR;
      end
    end
  end

  // byte sequence: optional escape, then the byte, each possibly encoded
  always_comb begin
    if (url_encode_on) begin
      bs_bytes = {sms_pkg::hex_upper(4'hC), sms_pkg::hex_upper(4'h5), sms_pkg::CH_PERCENT};
    end else begin
      bs_bytes = {8'h00, 8'h00, sms_pkg::CH_BACKSLASH};
    end
    bs_len = quote ? (url_encode_on ? 3'd3 : 3'd1) : 3'd0;
    if (url_encode_on && !sms_pkg::is_unreserved(c_mod)) begin
      ch_bytes = {sms_pkg::hex_upper(c_mod[3:0]), sms_pkg::hex_upper(c_mod[7:4]),
                  sms_pkg::CH_PERCENT};
      ch_len   = 3'd3;
    end else begin
      ch_bytes = {8'h00, 8'h00, c_mod};
      ch_len   = 3'd1;
    end
    n = bs_len + ch_len;
    for (int i = 0; i < sms_pkg::SEQ_MAX; i++) begin
      if (3'(i) < bs_len) begin
        seq[i] = bs_bytes[i[1:0]];
      end else begin
        seq[i] = ch_bytes[2'(3'(i) - bs_len)];
      end
    end
  end

  // decimal count plus n, sticking at all nines
  always_comb begin
    sum0  = {1'b0, count_digits[0]} + {2'b00, n};
    carry = sum0 >= 5'd10;
    count_next[0] = carry ? 4'(sum0 - 5'd10) : sum0[3:0];
    for (int i = 1; i < COUNT_DIGITS; i++) begin
      if (carry) begin
        count_next[i] = (count_digits[i] == 4'd9) ? 4'd0 : count_digits[i] + 4'd1;
      end else begin
        count_next[i] = count_digits[i];
      end
      carry = carry && count_digits[i] == 4'd9;
    end
    if (carry) begin
      for (int i = 0; i < COUNT_DIGITS; i++) begin
        count_next[i] = 4'd9;
      end
    end
  end

  always_comb begin
    q_entry.is_count = length_on;
    q_entry.last     = in_data.is_last;
    q_entry.n        = n;
    q_entry.seq      = seq;
    q_digits         = in_data.is_empty ? '0 : count_next;
    if (length_on) begin
      q_push = accept && (in_data.is_empty || in_data.is_last);
    end else begin
      q_push = accept && !in_data.is_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      case_mode     <= '0;
      first_mode    <= '0;
      quote_mode    <= '0;
      url_encode_on <= 1'b0;
      length_on     <= 1'b0;
      at_first_byte <= 1'b1;
      count_digits  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          sms_pkg::REG_CASE_MODE:  case_mode     <= cfg_wdata;
          sms_pkg::REG_FIRST_MODE: first_mode    <= cfg_wdata;
          sms_pkg::REG_QUOTE_MODE: quote_mode    <= cfg_wdata;
          sms_pkg::REG_URL_ENCODE: url_encode_on <= cfg_wdata[0];
          sms_pkg::REG_LENGTH_ON:  length_on     <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (accept) begin
        if (in_data.is_empty || in_data.is_last) begin
          at_first_byte <= 1'b1;
          count_digits  <= '0;
        end else begin
          at_first_byte <= 1'b0;
          count_digits  <= count_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sms_fifo.sv -----
// ----------------------------------------------------------------------------
// sms_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_fifo #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  full,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      rdata
);

  logic [1:0][WIDTH-1:0] mem;
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            fill;

  assign full      = fill == 2'd2;
  assign not_empty = fill != 2'd0;
  assign rdata     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sms_back.sv -----
// ----------------------------------------------------------------------------
// sms_back
// Takes queued jobs and sends them out one byte a beat: either the stored
// byte run or the count digits without leading zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_back #(
  parameter int COUNT_DIGITS = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire sms_pkg::entry_t               q_entry,
  input  wire logic [COUNT_DIGITS-1:0][3:0]  q_digits,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output sms_pkg::out_item_t                 out_data
);

  localparam int DW = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

  logic                          w_valid;
  sms_pkg::entry_t               w_entry;
  logic [COUNT_DIGITS-1:0][3:0]  w_digits;
  logic [2:0]                    seq_idx;
  logic [DW-1:0]                 dig_idx;

  logic          can_emit;
  logic          entry_done;
  logic [7:0]    byte_now;
  logic          last_now;
  logic [DW-1:0] top;

  assign can_emit = w_valid && (!out_valid || out_ready);
  assign q_pop    = q_valid && (!w_valid || (can_emit && entry_done));

  always_comb begin
    if (w_entry.is_count) begin
      entry_done = dig_idx == '0;
      byte_now   = sms_pkg::CH_ZERO + {4'h0, w_digits[dig_idx]};
      last_now   = entry_done;
    end else begin
      entry_done = seq_idx == w_entry.n - 3'd1;
      byte_now   = w_entry.seq[seq_idx];
      last_now   = entry_done && w_entry.last;
    end
  end

  // highest non-zero digit of the incoming count
  always_comb begin
    top = '0;
    for (int i = 1; i < COUNT_DIGITS; i++) begin
      if (q_digits[i] != 4'd0) begin
        top = DW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (can_emit) begin
        out_valid         <= 1'b1;
        out_data.out_byte <= byte_now;
        out_data.out_last <= last_now;
        if (!entry_done) begin
          seq_idx <= seq_idx + 3'd1;
          dig_idx <= dig_idx - DW'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        w_valid  <= 1'b1;
        w_entry  <= q_entry;
        w_digits <= q_digits;
        seq_idx  <= 3'd0;
        dig_idx  <= top;
      end else if (can_emit && entry_done) begin
        w_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/string_modifier_stream_top.sv -----
// ----------------------------------------------------------------------------
// string_modifier_stream_top
// Applies case, first-byte case, quoting, percent-encoding and length
// modifiers to a byte stream.
//
//   channel   direction  handshake            beat
//   in        input      in_valid/in_ready    one string byte or empty mark
//   out       output     out_valid/out_ready  one result byte
//   cfg       input      cfg_we               one register write
//
// A byte is taken every cycle while the two-entry queue has room; the back
// sends one result beat a cycle while out_ready is high; a byte makes 1 to
// 6 beats and a count printout 1 to COUNT_DIGITS beats. A first beat passes
// the queue, the back's job register and the output register, which holds
// a beat while out_ready is low; the front accepts until the queue fills.
// Reset clears the registers, the count and the queue; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module string_modifier_stream_top #(
  parameter int COUNT_DIGITS = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [sms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [sms_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire sms_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output sms_pkg::out_item_t                   out_data
);

  localparam int EW = $bits(sms_pkg::entry_t);
  localparam int QW = EW + 4 * COUNT_DIGITS;

  logic                          q_full;
  logic                          q_push;
  logic                          q_pop;
  logic                          q_valid;
  sms_pkg::entry_t               f_entry;
  logic [COUNT_DIGITS-1:0][3:0]  f_digits;
  logic [QW-1:0]                 q_rdata;
  sms_pkg::entry_t               b_entry;
  logic [COUNT_DIGITS-1:0][3:0]  b_digits;

  sms_front #(.COUNT_DIGITS(COUNT_DIGITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (f_entry),
    .q_digits  (f_digits)
  );

  sms_fifo #(.WIDTH(QW)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wdata     ({f_entry, f_digits}),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rdata     (q_rdata)
  );

  assign b_entry  = q_rdata[QW-1 -: EW];
  assign b_digits = q_rdata[4*COUNT_DIGITS-1:0];

  sms_back #(.COUNT_DIGITS(COUNT_DIGITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_entry   (b_entry),
    .q_digits  (b_digits),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
